>>> design/dhbd_pkg.sv
`timescale 1ns / 1ps
package dhbd_pkg;
    localparam int NUM_CLASSES_DEF = 2;
    localparam int FINEST_STRIDE_LOG2_DEF = 3;
    localparam int LOGIT_W = 16;
    localparam int PROB_W = 16;
    localparam int BOX_W = 14;
    localparam int CFG_W = 60;
    localparam int NUM_LANES = 6;

    localparam logic [2:0] REG_NET_WIDTH = 3'd0;
    localparam logic [2:0] REG_NET_HEIGHT = 3'd1;
    localparam logic [2:0] REG_SCORE_THR = 3'd2;
    localparam logic [2:0] REG_SCALE_X = 3'd3;
    localparam logic [2:0] REG_SCALE_Y = 3'd4;
    localparam logic [2:0] REG_ANCH_FINE = 3'd5;
    localparam logic [2:0] REG_ANCH_MID = 3'd6;
    localparam logic [2:0] REG_ANCH_COARSE = 3'd7;

    typedef struct packed {
        logic       last;
        logic [1:0] sc;
        logic [1:0] an;
        logic [7:0] row;
        logic [7:0] col;
    } pos_t;

    function automatic logic [16:0] pow2_neg(input logic [4:0] i);
        case (i)
            5'd0: pow2_neg = 17'd65536;
            5'd1: pow2_neg = 17'd62758;
            5'd2: pow2_neg = 17'd60097;
            5'd3: pow2_neg = 17'd57549;
            5'd4: pow2_neg = 17'd55108;
            5'd5: pow2_neg = 17'd52772;
            5'd6: pow2_neg = 17'd50535;
            5'd7: pow2_neg = 17'd48392;
            5'd8: pow2_neg = 17'd46341;
            5'd9: pow2_neg = 17'd44376;
            5'd10: pow2_neg = 17'd42495;
            5'd11: pow2_neg = 17'd40693;
            5'd12: pow2_neg = 17'd38968;
            5'd13: pow2_neg = 17'd37316;
            5'd14: pow2_neg = 17'd35734;
            5'd15: pow2_neg = 17'd34219;
            default: pow2_neg = 17'd32768;
        endcase
    endfunction
endpackage

>>> design/dhbd_sigmoid_lane.sv
`timescale 1ns / 1ps
module dhbd_sigmoid_lane (
    input  logic                            aclk,
    input  logic                            start,
    input  logic signed [dhbd_pkg::LOGIT_W-1:0] x,
    output logic                            done,
    output logic [dhbd_pkg::PROB_W-1:0]     y
);
    import dhbd_pkg::*;

    // 0 idle, 1 exp, 2..18 restoring divide of 2^32+d/2 by d
    logic [4:0]  step_reg;
    logic        neg_reg;
    logic [35:0] t_reg;
    logic [17:0] d_reg;
    logic [33:0] num_reg;
    logic [17:0] rem_reg;
    logic [17:0] quo_reg;
    logic        done_reg;
    logic [15:0] y_reg;

    logic [15:0] a;
    logic [19:0] n;
    logic [15:0] f;
    logic [16:0] p0, p1, p;
    logic [28:0] dprod;
    logic [16:0] e;
    logic [17:0] trial;

    always_comb begin
        a = x[LOGIT_W-1] ? 16'(-x) : 16'(x);
        n = t_reg[35:16];
        f = t_reg[15:0];
        p0 = pow2_neg({1'b0, f[15:12]});
        p1 = pow2_neg({1'b0, f[15:12]} + 5'd1);
        dprod = 29'(p0 - p1) * 29'(f[11:0]);
        p = p0 - 17'(dprod >> 12);
        e = (n < 20'd32) ? (p >> n[4:0]) : 17'd0;
        trial = {rem_reg[16:0], num_reg[33]};
    end

    always_ff @(posedge aclk) begin
        done_reg <= 1'b0;
        if (start) begin
            neg_reg <= x[LOGIT_W-1];
            t_reg <= 36'((36'(a) * 36'd94548) >> 8);
            step_reg <= 5'd1;
        end else if (step_reg == 5'd1) begin
            d_reg <= 18'd65536 + 18'(e);
            num_reg <= 34'h100000000 + 34'((18'd65536 + 18'(e)) >> 1);
            rem_reg <= '0;
            quo_reg <= '0;
            step_reg <= 5'd2;
        end else if (step_reg != 5'd0) begin
            // two quotient bits per step over 34 numerator bits
            logic [17:0] r1, r2;
            logic q1, q2;
            q1 = trial >= d_reg;
            r1 = q1 ? trial - d_reg : trial;
            r2 = {r1[16:0], num_reg[32]};
            q2 = r2 >= d_reg;
            r2 = q2 ? r2 - d_reg : r2;
            rem_reg <= r2;
            num_reg <= {num_reg[31:0], 2'b00};
            quo_reg <= {quo_reg[15:0], q1, q2};
            step_reg <= (step_reg == 5'd18) ? 5'd0 : step_reg + 5'd1;
            if (step_reg == 5'd18) begin
                done_reg <= 1'b1;
            end
        end
    end

    always_comb begin
        logic [16:0] sres;
        sres = (quo_reg[17] || quo_reg[16]) ? 17'd65536 : quo_reg[16:0];
        if (neg_reg) begin
            sres = 17'd65536 - sres;
        end
        y_reg = (sres > 17'd65535) ? 16'hFFFF : sres[15:0];
    end

    assign done = done_reg;
    assign y = y_reg;
endmodule

>>> design/dhbd_merge.sv
`timescale 1ns / 1ps
module dhbd_merge #(
    parameter int FINEST_STRIDE_LOG2 = dhbd_pkg::FINEST_STRIDE_LOG2_DEF
) (
    input  logic                                aclk,
    input  logic                                start,
    input  logic [dhbd_pkg::NUM_LANES*16-1:0]   probs,
    input  logic                                cls,
    input  dhbd_pkg::pos_t                      pos,
    input  logic [15:0]                         thr,
    input  logic [15:0]                         scale_x,
    input  logic [15:0]                         scale_y,
    input  logic [9:0]                          aw,
    input  logic [9:0]                          ah,
    output logic                                done,
    output logic [74:0]                         res
);
    import dhbd_pkg::*;

    logic [3:0]  st_reg;
    logic        found_reg, done_reg;
    logic [31:0] sw2_reg, sh2_reg;
    logic [33:0] w_reg, h_reg;
    logic signed [40:0] cx_reg, cy_reg;
    logic signed [42:0] l_reg, t_reg;
    logic signed [59:0] lp_reg, tp_reg;
    logic [50:0] wp_reg, hp_reg;
    logic [74:0] res_reg;

    logic [15:0] sx, sy, sw, shh, obj, conf;
    logic [13:0] wsat, hsat;
    assign sx = probs[15:0];
    assign sy = probs[31:16];
    assign sw = probs[47:32];
    assign shh = probs[63:48];
    assign obj = probs[79:64];
    assign conf = probs[95:80];
    assign wsat = (wp_reg[50:24] > 27'd16383) ? 14'h3FFF : wp_reg[37:24];
    assign hsat = (hp_reg[50:24] > 27'd16383) ? 14'h3FFF : hp_reg[37:24];

    function automatic logic signed [13:0] sat_s(input logic signed [59:0] v);
        logic signed [59:0] q;
        q = v / 60'sd16777216;
        if (q < -60'sd8192) sat_s = -14'sd8192;
        else if (q > 60'sd8191) sat_s = 14'sd8191;
        else sat_s = q[13:0];
    endfunction

    always_ff @(posedge aclk) begin
        done_reg <= 1'b0;
        case (st_reg)
            4'd0: begin
                if (start) begin
                    found_reg <= (obj > thr) && (conf > thr);
                    sw2_reg <= 32'(sw) * 32'(sw);
                    sh2_reg <= 32'(shh) * 32'(shh);
                    cx_reg <= (41'(sx) * 2 - 41'sd32768 + (41'(pos.col) <<< 16))
                        <<< (FINEST_STRIDE_LOG2 + pos.sc);
                    cy_reg <= (41'(sy) * 2 - 41'sd32768 + (41'(pos.row) <<< 16))
                        <<< (FINEST_STRIDE_LOG2 + pos.sc);
                    st_reg <= 4'd1;
                end
            end
            4'd1: begin
                w_reg <= 34'(sw2_reg >> 14) * 34'(aw);
                h_reg <= 34'(sh2_reg >> 14) * 34'(ah);
                st_reg <= 4'd2;
            end
            4'd2: begin
                l_reg <= 43'(cx_reg) - 43'(w_reg >> 1);
                t_reg <= 43'(cy_reg) - 43'(h_reg >> 1);
                wp_reg <= 51'(w_reg) * 51'(scale_x);
                hp_reg <= 51'(h_reg) * 51'(scale_y);
                st_reg <= 4'd3;
            end
            4'd3: begin
                lp_reg <= 60'(l_reg) * $signed({44'd0, scale_x});
                tp_reg <= 60'(t_reg) * $signed({44'd0, scale_y});
                st_reg <= 4'd4;
            end
            default: begin
                if (found_reg) begin
                    res_reg <= {hsat, wsat, sat_s(tp_reg), sat_s(lp_reg), conf, cls,
                        pos.last, 1'b1};
                end else begin
                    res_reg <= {73'd0, pos.last, 1'b0};
                end
                done_reg <= 1'b1;
                st_reg <= 4'd0;
            end
        endcase
    end

    assign done = done_reg;
    assign res = res_reg;
endmodule

>>> design/detection_head_box_decoder.sv
`timescale 1ns / 1ps
// channel | dir | data fields (low bit up)                          | tuser/tlast
// s_      | in  | tdata: x,y,w,h,object,class0,class1 logits (7x16) | -
// m_      | out | tdata: class_id,confidence,left,top,width,height  | tuser=found, tlast=last_cell
// cfg_    | in  | cfg_data: register value, cfg_index selects        | -
// A row passes through a load, the lane sigmoid (exp step, divisor setup, 17 two-bit
// divide steps), the box merge and the m_ register before the next row is accepted.
// A stalled result holds the m_ register; the next row's merge result then waits in
// the merge (hold_reg) and s_tready stays low until that result is loaded into m_.
// aresetn synchronous active low clears counters and config to defaults.
module detection_head_box_decoder #(
    parameter int NUM_CLASSES = dhbd_pkg::NUM_CLASSES_DEF,
    parameter int FINEST_STRIDE_LOG2 = dhbd_pkg::FINEST_STRIDE_LOG2_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // x,y,w,h,obj,cls0,cls1
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata,   // class_id,confidence,left,top,width,height,pad
    output logic         m_tuser,   // found
    output logic         m_tlast,   // last_cell
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [59:0]  cfg_data
);
    import dhbd_pkg::*;

    logic [11:0] nw_reg, nh_reg;
    logic [15:0] thr_reg, sx_reg, sy_reg;
    logic [59:0] af_reg, am_reg, ac_reg;
    logic [1:0]  sc_reg, an_reg;
    logic [7:0]  row_reg, col_reg;
    logic [1:0]  st_reg;
    pos_t        pos_reg;
    logic        cls_reg;
    logic [15:0] lg_reg [NUM_LANES];
    logic        mv_reg;
    logic        hold_reg;
    logic [74:0] mres_reg;

    logic [NUM_LANES-1:0] ldone;
    logic [NUM_LANES*16-1:0] probs;
    logic mdone;
    logic [74:0] mres;
    logic [3:0] sh;
    logic [8:0] gx, gy;
    logic col_end, row_end;
    logic signed [15:0] c0, c1;
    logic take;
    logic load_out;
    logic [59:0] anc;
    logic [19:0] apair;

    assign s_tready = (st_reg == 2'd0);
    assign take = s_tvalid && s_tready;
    assign load_out = (st_reg == 2'd3) && (mdone || hold_reg) && (!mv_reg || m_tready);
    assign c0 = s_tdata[95:80];
    assign c1 = s_tdata[111:96];

    always_comb begin
        logic [11:0] g1, g2;
        sh = 4'(FINEST_STRIDE_LOG2) + {2'd0, sc_reg};
        g1 = nw_reg >> sh;
        g2 = nh_reg >> sh;
        gx = (g1 == 0) ? 9'd1 : (g1 > 12'd256 ? 9'd256 : g1[8:0]);
        gy = (g2 == 0) ? 9'd1 : (g2 > 12'd256 ? 9'd256 : g2[8:0]);
        col_end = {1'b0, col_reg} >= gx - 9'd1;
        row_end = {1'b0, row_reg} >= gy - 9'd1;
        anc = (pos_reg.sc == 2'd0) ? af_reg : (pos_reg.sc == 2'd1 ? am_reg : ac_reg);
        apair = anc[20*pos_reg.an +: 20];
    end

    genvar g;
    generate
        for (g = 0; g < NUM_LANES; g++) begin : g_lane
            dhbd_sigmoid_lane u_lane (
                .aclk(aclk), .start(st_reg == 2'd1), .x(lg_reg[g]),
                .done(ldone[g]), .y(probs[g*16 +: 16])
            );
        end
    endgenerate

    dhbd_merge #(.FINEST_STRIDE_LOG2(FINEST_STRIDE_LOG2)) u_merge (
        .aclk(aclk), .start(st_reg == 2'd2 && (&ldone)), .probs(probs),
        .cls(cls_reg), .pos(pos_reg), .thr(thr_reg), .scale_x(sx_reg),
        .scale_y(sy_reg), .aw(apair[9:0]), .ah(apair[19:10]),
        .done(mdone), .res(mres)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nw_reg <= 12'd640; nh_reg <= 12'd640; thr_reg <= 16'd16384;
            sx_reg <= 16'd256; sy_reg <= 16'd256;
            af_reg <= '0; am_reg <= '0; ac_reg <= '0;
            sc_reg <= '0; an_reg <= '0; row_reg <= '0; col_reg <= '0;
            st_reg <= '0; mv_reg <= 1'b0; hold_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_NET_WIDTH: nw_reg <= cfg_data[11:0];
                    REG_NET_HEIGHT: nh_reg <= cfg_data[11:0];
                    REG_SCORE_THR: thr_reg <= cfg_data[15:0];
                    REG_SCALE_X: sx_reg <= cfg_data[15:0];
                    REG_SCALE_Y: sy_reg <= cfg_data[15:0];
                    REG_ANCH_FINE: af_reg <= cfg_data;
                    REG_ANCH_MID: am_reg <= cfg_data;
                    REG_ANCH_COARSE: ac_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (load_out) begin
                mres_reg <= mres;
                mv_reg <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                mv_reg <= 1'b0;
            end
            case (st_reg)
                2'd0: if (take) begin
                    for (int k = 0; k < 5; k++) lg_reg[k] <= s_tdata[16*k +: 16];
                    cls_reg <= (NUM_CLASSES >= 2) && (c1 > c0);
                    lg_reg[5] <= ((NUM_CLASSES >= 2) && (c1 > c0)) ? c1 : c0;
                    pos_reg <= '{last: col_end && row_end && an_reg == 2 && sc_reg == 2,
                        sc: sc_reg, an: an_reg, row: row_reg, col: col_reg};
                    if (!col_end) col_reg <= col_reg + 8'd1;
                    else begin
                        col_reg <= '0;
                        if (!row_end) row_reg <= row_reg + 8'd1;
                        else begin
                            row_reg <= '0;
                            if (an_reg < 2) an_reg <= an_reg + 2'd1;
                            else begin
                                an_reg <= '0;
                                sc_reg <= (sc_reg < 2) ? sc_reg + 2'd1 : 2'd0;
                            end
                        end
                    end
                    st_reg <= 2'd1;
                end
                2'd1: st_reg <= 2'd2;
                2'd2: if (&ldone) st_reg <= 2'd3;
                default: if (load_out) begin
                    hold_reg <= 1'b0;
                    st_reg <= 2'd0;
                end else if (mdone) begin
                    hold_reg <= 1'b1;
                end
            endcase
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tuser = mres_reg[0];
    assign m_tlast = mres_reg[1];
    assign m_tdata = {7'd0, mres_reg[74:2]};

    assert property (@(posedge aclk) disable iff (!aresetn)
        mdone |-> (st_reg == 2'd3) && !hold_reg) else $error("merge result lost");
    assert property (@(posedge aclk) disable iff (!aresetn) take |=> !s_tready)
        else $error("ready after take");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0)) else $error("not found nonzero");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import dhbd_pkg::*;

    typedef struct {
        bit          found;
        bit          last;
        bit          cid;
        bit [15:0]   conf;
        bit [13:0]   left;
        bit [13:0]   top;
        bit [13:0]   bw;
        bit [13:0]   bh;
    } box_t;

    typedef struct {
        logic signed [15:0] lg [7];
        bit                 known;
        box_t               res;
    } row_t;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [79:0]  m_tdata;   // class_id,confidence,left,top,width,height,pad
    logic         m_tuser;   // found
    logic         m_tlast;   // last_cell
    logic         cfg_we = 0;
    logic [2:0]   cfg_index = '0;
    logic [59:0]  cfg_data = '0;

    detection_head_box_decoder dut (.*);

    always #5 aclk = ~aclk;

    const int exp2_tab [17] = '{65536, 62758, 60097, 57549, 55108, 52772, 50535,
        48392, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

    int unsigned net_w, net_h, thr, scl_x, scl_y;
    bit [59:0]   anch [3];
    int unsigned pos_sc, pos_an, pos_row, pos_col;

    box_t  pending_boxes [$];
    int    n_errors = 0;
    int    n_rows = 0, n_found = 0, n_last = 0;
    bit    no_idle = 0;

    function automatic longint sig_q16(logic signed [15:0] x);
        longint a, t, n, f, i, fr, p, e, d, s;
        a = (x < 0) ? -longint'(x) : longint'(x);
        t = (a * 94548) >>> 8;
        n = t >>> 16;
        f = t & 'hFFFF;
        i = f >>> 12;
        fr = f & 'hFFF;
        p = exp2_tab[i] - (((exp2_tab[i] - exp2_tab[i + 1]) * fr) >>> 12);
        e = (n < 32) ? (p >>> n) : 0;
        d = 65536 + e;
        s = ((longint'(1) << 32) + d / 2) / d;
        if (x < 0) s = 65536 - s;
        return (s > 65535) ? 65535 : s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int unsigned grid_len(int unsigned net, int unsigned sh);
        int unsigned g;
        g = net >> sh;
        if (g == 0) g = 1;
        if (g > 256) g = 256;
        return g;
    endfunction

    function automatic box_t decode_row(row_t r);
        box_t   b;
        int unsigned sc, an, sh, gx, gy;
        bit     cend, rend;
        longint best, conf, stride, aw, ah, cx, cy, w, h, sw, shh;
        bit     cid;
        b = '{default: 0};
        sc = pos_sc > 2 ? 2 : pos_sc;
        an = pos_an > 2 ? 2 : pos_an;
        sh = FINEST_STRIDE_LOG2_DEF + sc;
        gx = grid_len(net_w, sh);
        gy = grid_len(net_h, sh);
        cend = pos_col >= gx - 1;
        rend = pos_row >= gy - 1;
        b.last = cend && rend && an == 2 && sc == 2;
        if (sig_q16(r.lg[4]) > thr) begin
            best = r.lg[5];
            cid = 0;
            if (r.lg[6] > best) begin
                best = r.lg[6];
                cid = 1;
            end
            conf = sig_q16(best[15:0]);
            if (conf > thr) begin
                aw = (anch[sc] >> (20 * an)) & 'h3FF;
                ah = (anch[sc] >> (20 * an + 10)) & 'h3FF;
                stride = longint'(1) << sh;
                cx = (2 * sig_q16(r.lg[0]) - 32768 + longint'(pos_col) * 65536) * stride;
                cy = (2 * sig_q16(r.lg[1]) - 32768 + longint'(pos_row) * 65536) * stride;
                sw = sig_q16(r.lg[2]);
                shh = sig_q16(r.lg[3]);
                w = ((4 * sw * sw) / 65536) * aw;
                h = ((4 * shh * shh) / 65536) * ah;
                b.found = 1;
                b.cid = cid;
                b.conf = 16'(conf);
                b.left = 14'(clamp(((cx - w / 2) * longint'(scl_x)) / 16777216, -8192, 8191));
                b.top = 14'(clamp(((cy - h / 2) * longint'(scl_y)) / 16777216, -8192, 8191));
                b.bw = 14'(clamp((w * longint'(scl_x)) / 16777216, 0, 16383));
                b.bh = 14'(clamp((h * longint'(scl_y)) / 16777216, 0, 16383));
            end
        end
        if (!cend) begin
            pos_col = (pos_col + 1) & 'hFF;
        end else begin
            pos_col = 0;
            if (!rend) begin
                pos_row = (pos_row + 1) & 'hFF;
            end else begin
                pos_row = 0;
                if (an < 2) begin
                    pos_an = an + 1;
                end else begin
                    pos_an = 0;
                    pos_sc = sc < 2 ? sc + 1 : 0;
                end
            end
        end
        return b;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [59:0] val);
        @(negedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_NET_WIDTH: net_w = val[11:0];
            REG_NET_HEIGHT: net_h = val[11:0];
            REG_SCORE_THR: thr = val[15:0];
            REG_SCALE_X: scl_x = val[15:0];
            REG_SCALE_Y: scl_y = val[15:0];
            REG_ANCH_FINE: anch[0] = val;
            REG_ANCH_MID: anch[1] = val;
            REG_ANCH_COARSE: anch[2] = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 0;
    endtask

    task automatic send_row(row_t r);
        int   gap;
        box_t b;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1;
        s_tdata <= {r.lg[6], r.lg[5], r.lg[4], r.lg[3], r.lg[2], r.lg[1], r.lg[0]};
        do @(posedge aclk); while (!s_tready);
        b = decode_row(r);
        if (r.known) b = r.res;
        pending_boxes = {pending_boxes, b};
        n_rows++;
    endtask

    task automatic drain();
        wait (pending_boxes.size() == 0);
        repeat (40) @(posedge aclk);
    endtask

    function automatic logic signed [15:0] rand_logit();
        case ($urandom_range(0, 5))
            0: return 16'sd0;
            1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            2, 3: return $signed(16'($urandom_range(0, 4096))) - 16'sd2048;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [59:0] rand_anchors();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return 60'({$urandom, $urandom});
        endcase
    endfunction

    function automatic int unsigned pick(int unsigned a, int unsigned b, int unsigned r);
        case ($urandom_range(0, 5))
            0: return a;
            1: return b;
            default: return r;
        endcase
    endfunction

    // receiver and checker
    initial begin
        int   stall;
        box_t e;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                @(negedge aclk);
                m_tready <= 0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_tready <= 1;
            do @(posedge aclk); while (!m_tvalid);
            if (pending_boxes.size() == 0) begin
                $display("%0t: unexpected transfer found=%b last=%b data=%h",
                         $time, m_tuser, m_tlast, m_tdata);
                n_errors++;
            end else begin
                e = pending_boxes.pop_front();
                n_found += e.found;
                n_last += e.last;
                if (m_tuser !== e.found || m_tlast !== e.last || m_tdata[0] !== e.cid ||
                    m_tdata[16:1] !== e.conf || m_tdata[30:17] !== e.left ||
                    m_tdata[44:31] !== e.top || m_tdata[58:45] !== e.bw ||
                    m_tdata[72:59] !== e.bh) begin
                    $display("%0t: mismatch exp found=%b last=%b cls=%0d conf=%0d l=%0d t=%0d w=%0d h=%0d",
                             $time, e.found, e.last, e.cid, e.conf, $signed(e.left),
                             $signed(e.top), e.bw, e.bh);
                    $display("%0t:          got found=%b last=%b cls=%0d conf=%0d l=%0d t=%0d w=%0d h=%0d",
                             $time, m_tuser, m_tlast, m_tdata[0], m_tdata[16:1],
                             $signed(m_tdata[30:17]), $signed(m_tdata[44:31]),
                             m_tdata[58:45], m_tdata[72:59]);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        row_t  tbl [$];
        row_t  r;
        box_t  none;
        int    ph, k;
        none = '{default: 0};
        net_w = 640; net_h = 640; thr = 16384; scl_x = 256; scl_y = 256;
        anch = '{default: 0};
        pos_sc = 0; pos_an = 0; pos_row = 0; pos_col = 0;

        // all zero logits at the first cell: centre at 4 px, zero size
        r.lg = '{default: 16'sd0}; r.known = 1;
        r.res = '{found: 1, last: 0, cid: 0, conf: 32768, left: 4, top: 4, bw: 0, bh: 0};
        tbl = {tbl, r};
        // objectness floor and class floor: nothing found
        r.lg = '{0, 0, 0, 0, 16'sh8000, 0, 0}; r.known = 1; r.res = none;
        tbl = {tbl, r};
        r.lg = '{0, 0, 0, 0, 16'sh7FFF, 16'sh8000, 16'sh8000}; r.res = none;
        tbl = {tbl, r};
        r.known = 0;
        r.lg = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
        tbl = {tbl, r};   // class tie
        r.lg = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sd100, 16'sd200};
        tbl = {tbl, r};
        r.lg = '{16'sd5, -16'sd5, 16'sd256, -16'sd256, 16'sd1, -16'sd300, 16'sd300};
        tbl = {tbl, r};
        r.lg = '{0, 0, 0, 0, -16'sd281, 16'sd10, 16'sd10};   // near objectness threshold
        tbl = {tbl, r};
        r.lg = '{0, 0, 0, 0, -16'sd282, 16'sd10, 16'sd10};
        tbl = {tbl, r};
        r.lg = '{0, 0, 0, 0, 16'sd500, -16'sd281, -16'sd282};   // near class threshold
        tbl = {tbl, r};
        r.lg = '{16'sh5555, 16'shAAAA, 16'sh0F0F, 16'shF0F0, 16'sh1234, 16'shFEDC, 16'sh7FFE};
        tbl = {tbl, r};

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        foreach (tbl[i]) send_row(tbl[i]);
        @(negedge aclk);
        s_tvalid <= 0;
        drain();

        for (ph = 0; ph < 8; ph++) begin
            no_idle = (ph == 2 || ph == 5);
            write_reg(REG_NET_WIDTH, pick(0, 4095, $urandom_range(32, 127)));
            write_reg(REG_NET_HEIGHT, pick(2048, 32, $urandom_range(32, 127)));
            write_reg(REG_SCORE_THR, pick(0, 65535, $urandom_range(0, 1) ? 32768 : $urandom));
            write_reg(REG_SCALE_X, pick(0, 65535, $urandom_range(128, 1024)));
            write_reg(REG_SCALE_Y, pick(65535, 0, $urandom_range(128, 1024)));
            write_reg(REG_ANCH_FINE, rand_anchors());
            write_reg(REG_ANCH_MID, rand_anchors());
            write_reg(REG_ANCH_COARSE, rand_anchors());
            for (k = 0; k < 200; k++) begin
                r.known = 0;
                foreach (r.lg[j]) r.lg[j] = rand_logit();
                if ($urandom_range(0, 3) != 0) r.lg[4] = 16'($urandom_range(0, 32767));
                if (ph == 3 && k == 100) begin
                    @(negedge aclk);
                    s_tvalid <= 0;
                    wait (pending_boxes.size() == 0);
                end
                send_row(r);
            end
            @(negedge aclk);
            s_tvalid <= 0;
            drain();
        end

        $display("Sent %0d rows over 9 register settings: %0d boxes found, %0d frame ends.",
                 n_rows, n_found, n_last);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d transfers outstanding", pending_boxes.size());
        $display("CHECK FAILED");
        $finish;
    end
endmodule
